[rtl/core/mtf_pkg.sv]
// ----------------------------------------------------------------------------
// mtf_pkg
// Shared types and constants for the move-to-front coder and its list cells.
// ----------------------------------------------------------------------------
`default_nettype none

package mtf_pkg;

	// symbol and position width, fixed by the byte interface
	localparam int SYM_W = 8;

	// default number of symbols in the ordered list
	localparam int ALPHABET_SIZE = 256;

	// direction register codes
	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_FINISH
	} state_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic             init;   // reload identity order
		logic             dec;    // decode: match on position, not on contents
		logic [SYM_W-1:0] key;    // symbol to find, or position to take
	} cell_ctl_t;

	// what a cell reports when the search wave stops on it
	typedef struct packed {
		logic             hit;
		logic [SYM_W-1:0] sym;    // cell contents, zero when no hit
	} cell_rep_t;

endpackage

`default_nettype wire

[rtl/core/mtf_cell.sv]
// ----------------------------------------------------------------------------
// mtf_cell
// One entry of the move-to-front list. A search wave enters from the left
// neighbor with the entry that sat there; the cell takes it over and hands
// its own entry on, until the wave stops at the cell being promoted.
// ----------------------------------------------------------------------------
`default_nettype none

module mtf_cell #(
	parameter int IDX = 0
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire  mtf_pkg::cell_ctl_t   ctl,
	input  wire                        tok_in,
	input  wire  [mtf_pkg::SYM_W-1:0]  carry_in,
	input  wire                        front_we,
	input  wire  [mtf_pkg::SYM_W-1:0]  front_sym,
	output logic                       tok_out,
	output logic [mtf_pkg::SYM_W-1:0]  carry_out,
	output mtf_pkg::cell_rep_t         rep
);

	localparam logic [mtf_pkg::SYM_W-1:0] IDENT = mtf_pkg::SYM_W'(IDX);

	logic [mtf_pkg::SYM_W-1:0] entry_q;
	logic [mtf_pkg::SYM_W-1:0] carry_q;
	logic                      tok_q;
	logic                      hit;

	// wave stops here when the entry (encode) or the position (decode) matches
	always_comb begin
		hit = tok_in && (ctl.dec ? (IDENT == ctl.key) : (entry_q == ctl.key));
		rep.hit = hit;
		rep.sym = hit ? entry_q : '0;
	end

	// entry update and hand-off to the right neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= IDENT;
			tok_q   <= 1'b0;
		end else begin
			tok_q <= tok_in && !hit;
			if (ctl.init) begin
				entry_q <= IDENT;
			end else if (front_we) begin
				entry_q <= front_sym;
			end else if (tok_in) begin
				entry_q <= carry_in;
			end
		end
	end

	// entry handed on with the wave
	always_ff @(posedge clk) begin
		if (tok_in) begin
			carry_q <= entry_q;
		end
	end

	assign tok_out   = tok_q;
	assign carry_out = carry_q;

endmodule

`default_nettype wire

[rtl/core/move_to_front_coder.sv]
// ----------------------------------------------------------------------------
// move_to_front_coder
// Byte move-to-front encoder/decoder built as a chain of list cells.
// ----------------------------------------------------------------------------
// Flow: an accepted item starts a search wave that moves one cell per cycle
//   along the list; where it stops, the result is taken and then registered
//   onto out_valid. A byte outside the alphabet (encode) skips the search.
// Throughput: one item at a time; in_stall holds off the next item until the
//   result is delivered, and a stalled result holds off the next item.
// Reset: the list returns to identity order and direction to encode.
`default_nettype none

module move_to_front_coder #(
	parameter int ALPHABET_SIZE = mtf_pkg::ALPHABET_SIZE
) (
	input  wire                        clk,
	input  wire                        arst_n,
	// configuration
	input  wire                        cfg_wr_en,
	input  wire                        cfg_wr_data,
	// input items
	input  wire                        in_valid,
	output logic                       in_stall,
	input  wire  [mtf_pkg::SYM_W-1:0]  symbol_in,
	input  wire                        block_start,
	// result items
	output logic                       out_valid,
	input  wire                        out_stall,
	output logic [mtf_pkg::SYM_W-1:0]  symbol_out
);

	localparam int CW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
	localparam logic [mtf_pkg::SYM_W:0]   SIZE_EXT = (mtf_pkg::SYM_W + 1)'(ALPHABET_SIZE);
	localparam logic [mtf_pkg::SYM_W-1:0] LAST_POS = mtf_pkg::SYM_W'(ALPHABET_SIZE - 1);
	localparam logic [CW-1:0]             LAST_CNT = CW'(ALPHABET_SIZE - 1);

	mtf_pkg::state_t state_q, state_d;

	logic                       direction_q;
	logic [mtf_pkg::SYM_W-1:0]  key_q;
	logic [mtf_pkg::SYM_W-1:0]  res_q;
	logic [mtf_pkg::SYM_W-1:0]  front_q;
	logic                       move_q;
	logic [CW-1:0]              cnt_q;
	logic                       out_valid_q;
	logic [mtf_pkg::SYM_W-1:0]  out_data_q;

	logic                       accept;
	logic                       escape;
	logic                       deliver;
	logic                       front_we;
	logic                       any_hit;
	logic [mtf_pkg::SYM_W-1:0]  hit_sym;
	mtf_pkg::cell_ctl_t         ctl;

	logic [ALPHABET_SIZE-1:0]                     tok;
	logic [ALPHABET_SIZE-1:0]                     hit_vec;
	logic [ALPHABET_SIZE-1:0][mtf_pkg::SYM_W-1:0] carry;
	mtf_pkg::cell_rep_t [ALPHABET_SIZE-1:0]       rep;

	// handshake and decode of the incoming item
	assign in_stall = (state_q != mtf_pkg::ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign escape   = (direction_q == mtf_pkg::DIR_ENCODE) &&
	                  ({1'b0, symbol_in} >= SIZE_EXT);
	assign deliver  = (state_q == mtf_pkg::ST_FINISH) && (!out_valid_q || !out_stall);
	assign front_we = (state_q == mtf_pkg::ST_FINISH) && move_q;

	// broadcast to the cells
	always_comb begin
		ctl.init = accept && block_start;
		ctl.dec  = (direction_q == mtf_pkg::DIR_DECODE);
		ctl.key  = key_q;
	end

	// cell chain
	genvar g;
	generate
		for (g = 0; g < ALPHABET_SIZE; g++) begin : g_cell
			logic                      tin;
			logic [mtf_pkg::SYM_W-1:0] cin;
			if (g == 0) begin : g_head
				assign tin = (state_q == mtf_pkg::ST_SEARCH) && (cnt_q == '0);
				assign cin = '0;
			end else begin : g_body
				assign tin = tok[g-1];
				assign cin = carry[g-1];
			end
			mtf_cell #(
				.IDX (g)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.tok_in    (tin),
				.carry_in  (cin),
				.front_we  ((g == 0) ? front_we : 1'b0),
				.front_sym (front_q),
				.tok_out   (tok[g]),
				.carry_out (carry[g]),
				.rep       (rep[g])
			);
			assign hit_vec[g] = rep[g].hit;
		end
	endgenerate

	// collect the report of the one cell the wave stopped on
	always_comb begin
		any_hit = 1'b0;
		hit_sym = '0;
		for (int i = 0; i < ALPHABET_SIZE; i++) begin
			any_hit = any_hit | rep[i].hit;
			hit_sym = hit_sym | rep[i].sym;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mtf_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = escape ? mtf_pkg::ST_FINISH : mtf_pkg::ST_SEARCH;
				end
			end
			mtf_pkg::ST_SEARCH: begin
				if (any_hit) begin
					state_d = mtf_pkg::ST_FINISH;
				end
			end
			mtf_pkg::ST_FINISH: begin
				if (deliver) begin
					state_d = mtf_pkg::ST_IDLE;
				end
			end
			default: state_d = mtf_pkg::ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mtf_pkg::ST_IDLE;
			direction_q <= mtf_pkg::DIR_ENCODE;
			cnt_q       <= '0;
			move_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				direction_q <= cfg_wr_data;
			end
			if (accept) begin
				cnt_q  <= '0;
				move_q <= !escape;
			end else if ((state_q == mtf_pkg::ST_SEARCH) && !any_hit && (cnt_q != LAST_CNT)) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (deliver) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			if (direction_q == mtf_pkg::DIR_DECODE && ({1'b0, symbol_in} >= SIZE_EXT)) begin
				key_q <= LAST_POS;
			end else begin
				key_q <= symbol_in;
			end
			res_q <= symbol_in;
		end else if ((state_q == mtf_pkg::ST_SEARCH) && any_hit) begin
			if (direction_q == mtf_pkg::DIR_DECODE) begin
				res_q   <= hit_sym;
				front_q <= hit_sym;
			end else begin
				res_q   <= mtf_pkg::SYM_W'(cnt_q);
				front_q <= key_q;
			end
		end
		if (deliver) begin
			out_data_q <= res_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign symbol_out = out_data_q;

	// the search wave stops in at most one cell
	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec))
		else $error("more than one cell matched");

	// at most one cell holds the wave
	a_one_tok: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok))
		else $error("search wave split");

	// cells only report while a search is running
	a_hit_search: assert property (@(posedge clk) disable iff (!arst_n)
		any_hit |-> (state_q == mtf_pkg::ST_SEARCH))
		else $error("cell hit outside search");

	// a search always ends within the list
	a_search_end: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == mtf_pkg::ST_SEARCH) && (cnt_q == LAST_CNT)) |-> any_hit)
		else $error("search ran off the end of the list");

endmodule

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for move_to_front_coder: a queue-fed driver offers
// bytes or positions in bursts, a scoreboard predicts every result from its
// own copy of the symbol list, and a monitor checks results in order while
// the receiver stalls on its own pattern and once holds off for a long time.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int ALPHA            = mtf_pkg::ALPHABET_SIZE;
	localparam int ITEMS_PER_PHASE  = 142;
	localparam int NUM_PHASES       = 6;
	localparam int LONG_HOLD_AT     = 250;
	localparam int LONG_HOLD_CYCLES = 600;
	localparam int SETTLE_CYCLES    = 300;
	localparam int MAX_REPORTS      = 10;

	typedef struct packed {
		logic [mtf_pkg::SYM_W-1:0] sym;
		logic                      start;
	} mtf_item_t;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic                      clk;
	logic                      arst_n      = 1'b0;
	logic                      cfg_wr_en   = 1'b0;
	logic                      cfg_wr_data = 1'b0;
	logic                      in_valid    = 1'b0;
	logic                      in_stall;
	logic [mtf_pkg::SYM_W-1:0] symbol_in   = '0;
	logic                      block_start = 1'b0;
	logic                      out_valid;
	logic                      out_stall   = 1'b0;
	logic [mtf_pkg::SYM_W-1:0] symbol_out;

	// scoreboard state: predicted list and direction
	logic [mtf_pkg::SYM_W-1:0] order_model [ALPHA];
	logic                      dir_model;
	mtf_item_t                 pending_q[$];
	logic [mtf_pkg::SYM_W-1:0] expected_sym_q[$];
	int                        err_count    = 0;
	int                        results_seen = 0;

	move_to_front_coder #(
		.ALPHABET_SIZE(ALPHA)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.symbol_in  (symbol_in),
		.block_start(block_start),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.symbol_out (symbol_out)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#(15_000_000);
		$display("Test completed with failures");
		$finish;
	end

	function automatic void note_failure(input string msg);
		err_count++;
		if (err_count <= MAX_REPORTS) begin
			$display("[%0t] ERROR: %s", $realtime, msg);
		end
	endfunction

	function automatic void reset_order();
		for (int k = 0; k < ALPHA; k++) begin
			order_model[k] = k[mtf_pkg::SYM_W-1:0];
		end
	endfunction

	// entry at pos goes to the front, entries ahead of it shift back one
	function automatic void move_to_front(input int pos);
		logic [mtf_pkg::SYM_W-1:0] hit;
		hit = order_model[pos];
		for (int k = pos; k > 0; k--) begin
			order_model[k] = order_model[k-1];
		end
		order_model[0] = hit;
	endfunction

	// expected symbol_out for one item; updates the predicted list
	function automatic logic [mtf_pkg::SYM_W-1:0] mtf_step(
			input logic [mtf_pkg::SYM_W-1:0] sym, input logic start);
		int                        pos;
		bit                        found;
		logic [mtf_pkg::SYM_W-1:0] res;
		if (start) begin
			reset_order();
		end
		if (dir_model == mtf_pkg::DIR_ENCODE) begin
			res   = sym;
			found = 1'b0;
			pos   = 0;
			for (int k = 0; k < ALPHA; k++) begin
				if (!found && order_model[k] == sym) begin
					found = 1'b1;
					pos   = k;
				end
			end
			// a byte outside the alphabet passes through and leaves the list alone
			if (found) begin
				res = pos[mtf_pkg::SYM_W-1:0];
				move_to_front(pos);
			end
		end else begin
			// positions past the end saturate to the last entry
			pos = (int'(sym) >= ALPHA) ? ALPHA - 1 : int'(sym);
			res = order_model[pos];
			move_to_front(pos);
		end
		return res;
	endfunction

	task automatic push_item(input logic [mtf_pkg::SYM_W-1:0] sym, input logic start);
		mtf_item_t it;
		it.sym   = sym;
		it.start = start;
		pending_q.push_back(it);
	endtask

	// wait until every queued item is accepted and every result has come
	task automatic drain();
		do @(negedge clk);
		while (pending_q.size() != 0 || in_valid || expected_sym_q.size() != 0);
	endtask

	// direction write, only while the block is idle
	task automatic set_direction(input logic d);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= d;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		dir_model = d;
		@(negedge clk);
	endtask

	// driver: bursts of items with random gaps, prediction at acceptance
	always @(posedge clk or negedge arst_n) begin : drive_items
		mtf_item_t nxt;
		logic      valid_next;
		int        burst_left;
		int        gap_left;
		if (!arst_n) begin
			in_valid    <= 1'b0;
			symbol_in   <= '0;
			block_start <= 1'b0;
			burst_left = 1;
			gap_left   = 0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_sym_q.push_back(mtf_step(symbol_in, block_start));
			end
			// a stalled item stays on the port unchanged
			valid_next = in_valid && in_stall;
			if (!valid_next) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_q.size() > 0) begin
					nxt = pending_q.pop_front();
					symbol_in   <= nxt.sym;
					block_start <= nxt.start;
					valid_next = 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
			end
			in_valid <= valid_next;
		end
	end

	// receiver: stall pattern in modes, plus one long hold-off
	always @(posedge clk or negedge arst_n) begin : drive_stall
		stall_mode_t mode;
		int          mode_left;
		int          hold_left;
		int          pat_cnt;
		bit          hold_done;
		logic        stall_next;
		if (!arst_n) begin
			out_stall <= 1'b0;
			mode      = STALL_NONE;
			mode_left = 0;
			hold_left = 0;
			pat_cnt   = 0;
			hold_done = 1'b0;
		end else begin
			stall_next = 1'b0;
			if (hold_left > 0) begin
				hold_left--;
				stall_next = 1'b1;
			end else if (!hold_done && results_seen >= LONG_HOLD_AT) begin
				// block fills up behind this while the sender keeps offering
				hold_left  = LONG_HOLD_CYCLES - 1;
				hold_done  = 1'b1;
				stall_next = 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode      = stall_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(16, 200);
				end else begin
					mode_left--;
				end
				pat_cnt = (pat_cnt + 1) % 5;
				case (mode)
					STALL_NONE:     stall_next = 1'b0;
					STALL_LIGHT:    stall_next = ($urandom_range(0, 3) == 0);
					STALL_HEAVY:    stall_next = ($urandom_range(0, 3) != 0);
					STALL_PERIODIC: stall_next = (pat_cnt < 2);
					default:        stall_next = 1'b0;
				endcase
			end
			out_stall <= stall_next;
		end
	end

	// monitor: in-order compare against the oldest prediction
	always @(posedge clk) begin : check_results
		logic [mtf_pkg::SYM_W-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen <= results_seen + 1;
			if (expected_sym_q.size() == 0) begin
				note_failure($sformatf("unexpected result, symbol_out %0d", symbol_out));
			end else begin
				want = expected_sym_q.pop_front();
				if (symbol_out !== want) begin
					note_failure($sformatf("symbol_out mismatch: expected %0d, got %0d",
						want, symbol_out));
				end
			end
		end
	end

	// stimulus
	initial begin : stimulus
		logic [mtf_pkg::SYM_W-1:0] work_set [8];
		logic [5:0]                dir_pattern;
		logic                      dir;
		logic [mtf_pkg::SYM_W-1:0] s;
		logic                      st;
		int                        left;
		int                        n;
		int                        r;
		reset_order();
		dir_model   = mtf_pkg::DIR_ENCODE;
		dir_pattern = 6'b101101;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed encode: extremes, repeats, block restart
		set_direction(mtf_pkg::DIR_ENCODE);
		push_item(8'h00, 1'b1);
		push_item(8'hFF, 1'b0);
		push_item(8'hFF, 1'b0);
		push_item(8'h00, 1'b0);
		push_item(8'h80, 1'b0);
		push_item(8'h55, 1'b0);
		push_item(8'hAA, 1'b0);
		push_item(8'hFF, 1'b1);
		push_item(8'h01, 1'b0);
		push_item(8'h01, 1'b0);
		push_item(8'hFE, 1'b0);
		drain();

		// directed decode: first and last positions, restart mid-stream
		set_direction(mtf_pkg::DIR_DECODE);
		push_item(8'h00, 1'b1);
		push_item(8'hFF, 1'b0);
		push_item(8'hFF, 1'b0);
		push_item(8'h01, 1'b0);
		push_item(8'h00, 1'b0);
		push_item(8'h80, 1'b0);
		push_item(8'hAA, 1'b1);
		push_item(8'h55, 1'b0);
		push_item(8'h00, 1'b0);
		push_item(8'hFE, 1'b0);
		drain();

		// random phases; each ends with the sender paused until all results are in
		for (int p = 0; p < NUM_PHASES; p++) begin
			dir = dir_pattern[p] ? mtf_pkg::DIR_DECODE : mtf_pkg::DIR_ENCODE;
			set_direction(dir);
			left = ITEMS_PER_PHASE;
			while (left > 0) begin
				n = $urandom_range(4, 40);
				if (n > left) begin
					n = left;
				end
				foreach (work_set[k]) begin
					work_set[k] = mtf_pkg::SYM_W'($urandom_range(0, 255));
				end
				// mostly blocks opened by a start flag, with stray restarts as noise
				for (int i = 0; i < n; i++) begin
					r  = $urandom_range(0, 99);
					st = (i == 0 && $urandom_range(0, 4) != 0) || ($urandom_range(0, 29) == 0);
					if (dir == mtf_pkg::DIR_ENCODE) begin
						s = (r < 65) ? work_set[3'($urandom_range(0, 7))] :
						               mtf_pkg::SYM_W'($urandom_range(0, 255));
					end else if (r < 60) begin
						s = mtf_pkg::SYM_W'($urandom_range(0, 7));
					end else if (r < 90) begin
						s = mtf_pkg::SYM_W'($urandom_range(0, 31));
					end else begin
						s = mtf_pkg::SYM_W'($urandom_range(0, 255));
					end
					push_item(s, st);
				end
				left -= n;
			end
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_sym_q.size() != 0) begin
			note_failure($sformatf("%0d results never arrived", expected_sym_q.size()));
		end
		if (err_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[move_to_front_coder.f]
rtl/core/mtf_pkg.sv
rtl/core/mtf_cell.sv
rtl/core/move_to_front_coder.sv
dv/tb_top.sv
